[rtl/u2h_pkg.sv]
// Shared types, constants and decode helpers for the UTF-8 to UTF-16 FNV-1a hasher.
package u2h_pkg;

  localparam logic [31:0] FNV_BASIS   = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME   = 32'h0100_0193;
  localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
  localparam logic [15:0] SURR_HI     = 16'hD800;
  localparam logic [15:0] SURR_LO     = 16'hDC00;
  localparam logic [20:0] SUPP_OFFSET = 21'h1_0000;
  localparam logic [20:0] BMP_MAX     = 21'h0_FFFF;

  // Lead classes: how many bytes a lead announces.
  localparam logic [2:0] LEN_BAD   = 3'd0;
  localparam logic [2:0] LEN_ASCII = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // One queue entry: the UTF-16 units that one byte releases.
  typedef struct packed {
    logic [2:0][15:0] unit;
    logic [1:0]       cnt;
    logic             last;
  } bundle_t;

  typedef struct packed {
    logic [15:0] u0;
    logic [15:0] u1;
    logic        two;
  } unit_pair_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7])                   len = LEN_ASCII;
    else if (b[7:5] == 3'b110)   len = LEN_TWO;
    else if (b[7:4] == 4'b1110)  len = LEN_THREE;
    else if (b[7:3] == 5'b11110) len = LEN_FOUR;
    else                         len = LEN_BAD;
    return len;
  endfunction

  // A byte taken alone: ASCII passes, anything else is the replacement unit.
  function automatic logic [15:0] single_unit(input logic [7:0] b);
    return b[7] ? REPL_UNIT : {8'h00, b};
  endfunction

  // Decode a complete 2..4 byte sequence into one unit or a surrogate pair.
  function automatic unit_pair_t decode_seq(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [2:0] kind);
    logic [20:0] cp;
    logic [20:0] s;
    unit_pair_t  r;
    case (kind)
      LEN_TWO:   cp = {10'd0, b0[4:0], b1[5:0]};
      LEN_THREE: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      default:   cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    s = cp - SUPP_OFFSET;
    if (cp > BMP_MAX) begin
      r.u0  = SURR_HI + {5'd0, s[20:10]};
      r.u1  = SURR_LO + {6'd0, s[9:0]};
      r.two = 1'b1;
    end else begin
      r.u0  = cp[15:0];
      r.u1  = 16'h0000;
      r.two = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/u2h_front.sv]
// Front end: takes UTF-8 bytes, buffers open sequences and emits UTF-16 unit bundles.
module u2h_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        data_byte,
  input  logic              is_last,
  input  logic              q_full,
  output logic              q_push,
  output u2h_pkg::bundle_t  q_data
);

  logic [7:0] pend_r [3];
  logic [7:0] pend_nxt [3];
  logic [1:0] pcnt_r, pcnt_nxt;
  logic [2:0] need_r, need_nxt;

  logic                 accept;
  logic [7:0]           b0, b1, b2;
  logic [2:0]           n;
  logic                 complete;
  logic [2:0]           kind;
  u2h_pkg::unit_pair_t  seq;
  u2h_pkg::bundle_t     bnd;

  assign full   = q_full;
  assign accept = push & ~q_full;

  // Assemble the byte buffer with the new byte at the next free place.
  assign b0 = (pcnt_r == 2'd0) ? data_byte : pend_r[0];
  assign b1 = (pcnt_r == 2'd1) ? data_byte : pend_r[1];
  assign b2 = (pcnt_r == 2'd2) ? data_byte : pend_r[2];
  assign n        = {1'b0, pcnt_r} + 3'd1;
  assign complete = (pcnt_r != 2'd0) && (n == need_r);
  assign kind     = u2h_pkg::lead_len(data_byte);
  assign seq      = u2h_pkg::decode_seq(b0, b1, b2, data_byte, need_r);

  always_comb begin
    pend_nxt   = pend_r;
    pcnt_nxt   = pcnt_r;
    need_nxt   = need_r;
    bnd.unit   = '0;
    bnd.cnt    = 2'd0;
    bnd.last   = is_last;
    if (pcnt_r == 2'd0) begin
      if (is_last || (kind < u2h_pkg::LEN_TWO)) begin
        bnd.unit[0] = u2h_pkg::single_unit(data_byte);
        bnd.cnt     = 2'd1;
      end else begin
        pend_nxt[0] = data_byte;
        pcnt_nxt    = 2'd1;
        need_nxt    = kind;
      end
    end else if (complete) begin
      bnd.unit[0] = seq.u0;
      bnd.unit[1] = seq.u1;
      bnd.cnt     = seq.two ? 2'd2 : 2'd1;
      pcnt_nxt    = 2'd0;
      need_nxt    = 3'd0;
    end else if (is_last) begin
      // Cut-short sequence: the lead becomes a replacement, the rest are re-read as leads.
      bnd.unit[0] = u2h_pkg::REPL_UNIT;
      if (pcnt_r == 2'd1) begin
        bnd.unit[1] = u2h_pkg::single_unit(data_byte);
        bnd.cnt     = 2'd2;
      end else if (u2h_pkg::lead_len(pend_r[1]) == u2h_pkg::LEN_TWO) begin
        bnd.unit[1] = {5'd0, pend_r[1][4:0], data_byte[5:0]};
        bnd.cnt     = 2'd2;
      end else begin
        bnd.unit[1] = u2h_pkg::single_unit(pend_r[1]);
        bnd.unit[2] = u2h_pkg::single_unit(data_byte);
        bnd.cnt     = 2'd3;
      end
    end else begin
      case (pcnt_r)
        2'd1:    pend_nxt[1] = data_byte;
        default: pend_nxt[2] = data_byte;
      endcase
      pcnt_nxt = pcnt_r + 2'd1;
    end
    if (is_last) begin
      pcnt_nxt = 2'd0;
      need_nxt = 3'd0;
    end
  end

  assign q_push = accept & (bnd.cnt != 2'd0);
  assign q_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
      need_r <= 3'd0;
    end else if (accept) begin
      pcnt_r <= pcnt_nxt;
      need_r <= need_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

[rtl/u2h_fifo.sv]
// Bundle queue between the byte front end and the hash back end.
module u2h_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u2h_pkg::bundle_t  wdata,
  output logic              full,
  input  logic              pop,
  output u2h_pkg::bundle_t  rdata,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u2h_pkg::bundle_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/u2h_back.sv]
// Back end: folds one UTF-16 unit per cycle unless stalled into the FNV-1a hash; holds the result.
module u2h_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u2h_pkg::bundle_t  head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [31:0]       hash_value
);

  logic [1:0]  idx_r;
  logic [31:0] hash_r;
  logic [31:0] out_hash_r;
  logic        out_vld_r;

  logic [15:0] unit_sel;
  logic        last_step;
  logic        deliver;
  logic        go;
  logic [31:0] folded;

  always_comb begin
    case (idx_r)
      2'd0:    unit_sel = head.unit[0];
      2'd1:    unit_sel = head.unit[1];
      default: unit_sel = head.unit[2];
    endcase
  end

  assign last_step = (idx_r == (head.cnt - 2'd1));
  assign deliver   = head.last & last_step;
  // Stall the final fold only while an untaken result still sits in the output register.
  assign go        = ~q_empty & (~deliver | ~out_vld_r | pop);
  assign folded    = (hash_r ^ {16'h0000, unit_sel}) * u2h_pkg::FNV_PRIME;
  assign q_pop     = go & last_step;

  assign empty      = ~out_vld_r;
  assign hash_value = out_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= 2'd0;
      hash_r    <= u2h_pkg::FNV_BASIS;
      out_vld_r <= 1'b0;
    end else begin
      if (go) begin
        idx_r  <= last_step ? 2'd0 : idx_r + 2'd1;
        hash_r <= deliver ? u2h_pkg::FNV_BASIS : folded;
      end
      if (go && deliver) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && deliver) begin
      out_hash_r <= folded;
    end
  end

endmodule

[rtl/utf8_to_utf16_fnv1a32_hash.sv]
// Top level of the UTF-8 to UTF-16 FNV-1a 32-bit string hasher.
//
// Push a string one UTF-8 byte per request on in_data_byte, with in_is_last set on its
// final byte; one 32-bit FNV-1a hash of the string's UTF-16 form comes out per string,
// oldest first, on out_hash_value while empty is low, and pop takes it. The front end
// accepts a byte every cycle that the bundle queue has room (full low), buffers the bytes
// of an open multi-byte sequence and hands the UTF-16 units that a byte releases (zero to
// three) to the queue as one bundle. The back end folds one unit per cycle through a
// single 32x32 multiplier while the queue holds a bundle and no untaken result stalls
// a final fold; a string cut short inside a sequence may release three units on its
// last byte. A result is loaded into the output register at the edge that folds its
// last unit, after its bundle has passed through the queue, and the next string folds
// all but its last unit while an untaken result waits.
// Continuation bytes are not checked:
// a byte that cannot lead a sequence hashes as U+FFFD, a sequence cut short by the end of
// the string turns its lead into U+FFFD and its trailing bytes are read again as leads,
// and code points above U+10FFFF still split into a pair whose units keep their low 16
// bits. QUEUE_DEPTH sets how many bundles may wait between the two halves.
module utf8_to_utf16_fnv1a32_hash #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_hash_value
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  u2h_pkg::bundle_t  q_in;
  u2h_pkg::bundle_t  q_head;

  // Decode bytes and release unit bundles.
  u2h_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .data_byte (in_data_byte),
    .is_last   (in_is_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // Hold bundles so each half can stall on its own.
  u2h_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  // Fold units into the running hash and deliver the result.
  u2h_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .hash_value (out_hash_value)
  );

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("bundle pushed into a full queue");

  // Every pushed bundle carries at least one unit.
  a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_in.cnt != 2'd0))
    else $error("empty bundle pushed");

  // Only a string's last byte can release three units.
  a_three_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && (q_in.cnt == 2'd3)) |-> q_in.last)
    else $error("three-unit bundle without end of string");

  // The back end only retires a bundle that is present.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("bundle retired from an empty queue");

endmodule

[bench/tb_utf8_to_utf16_fnv1a32_hash.sv]
// Self-checking bench for the UTF-8 to UTF-16 FNV-1a 32-bit string hasher.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_fnv1a32_hash;

  // Byte budget for the random part and the stall limit of the watchdog.
  localparam int RANDOM_BYTES = 1800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  // Hash and decode constants, kept apart from the design's own package.
  localparam logic [31:0] OFFSET_BASIS       = 32'h811C_9DC5;
  localparam logic [31:0] HASH_PRIME         = 32'h0100_0193;
  localparam logic [15:0] REPLACEMENT_UNIT   = 16'hFFFD;
  localparam logic [15:0] HIGH_SURR_BASE     = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE      = 16'hDC00;
  localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h1_0000;

  // What a byte announces when it is met as a lead: its sequence length.
  typedef enum int {
    LEAD_BAD   = 0,
    LEAD_ASCII = 1,
    LEAD_TWO   = 2,
    LEAD_THREE = 3,
    LEAD_FOUR  = 4
  } lead_e;

  // Tracks the hash of the string in flight and holds the hashes of finished
  // strings until the block hands them out.
  class utf16_hash_tracker;
    logic [31:0] running;
    logic [7:0]  held [3];
    int          held_count;
    int          want_len;
    logic [31:0] expected_hashes [$];
    int          errors;

    function void restart();
      running    = OFFSET_BASIS;
      held_count = 0;
      want_len   = 0;
    endfunction

    function void restart_sequence();
      held_count = 0;
      want_len   = 0;
    endfunction

    function new();
      errors = 0;
      restart();
    endfunction

    function lead_e lead_of(logic [7:0] b);
      if (b < 8'h80) return LEAD_ASCII;
      if ((b & 8'hE0) == 8'hC0) return LEAD_TWO;
      if ((b & 8'hF0) == 8'hE0) return LEAD_THREE;
      if ((b & 8'hF8) == 8'hF0) return LEAD_FOUR;
      return LEAD_BAD;
    endfunction

    function logic [31:0] fold_unit16(logic [31:0] h, logic [15:0] unit);
      logic [31:0] mixed;
      mixed = h ^ {16'h0000, unit};
      return mixed * HASH_PRIME;
    endfunction

    // Fold one code point: BMP values as one unit, the rest as a surrogate pair.
    function logic [31:0] fold_point(logic [31:0] h, logic [20:0] cp);
      logic [20:0] s;
      logic [31:0] acc;
      acc = h;
      if (cp > 21'h0_FFFF) begin
        s   = cp - SUPPLEMENTARY_BASE;
        acc = fold_unit16(acc, HIGH_SURR_BASE + {5'd0, s[20:10]});
        acc = fold_unit16(acc, LOW_SURR_BASE + {6'd0, s[9:0]});
      end else begin
        acc = fold_unit16(acc, cp[15:0]);
      end
      return acc;
    endfunction

    // Decode len bytes as complete text; a lead without room for its tail
    // turns into the replacement unit and the bytes after it are leads again.
    function logic [31:0] decode_span(logic [7:0] span [4], int len, logic [31:0] h);
      int          i;
      int          size;
      lead_e       kind;
      logic [20:0] cp;
      logic [31:0] acc;
      acc = h;
      i   = 0;
      while (i < len) begin
        kind = lead_of(span[i]);
        cp   = {5'd0, REPLACEMENT_UNIT};
        size = 1;
        if (kind == LEAD_ASCII) begin
          cp = {13'd0, span[i]};
        end else if (kind != LEAD_BAD && i + kind <= len) begin
          case (kind)
            LEAD_TWO:   cp = {16'd0, span[i][4:0]};
            LEAD_THREE: cp = {17'd0, span[i][3:0]};
            default:    cp = {18'd0, span[i][2:0]};
          endcase
          for (int k = 1; k < kind; k++) cp = (cp << 6) | {15'd0, span[i + k][5:0]};
          size = kind;
        end
        i   = i + size;
        acc = fold_point(acc, cp);
      end
      return acc;
    endfunction

    // Note one accepted byte; the last byte of a string queues its hash.
    function void take_byte(logic [7:0] b, logic last);
      logic [7:0] span [4];
      int         n;
      lead_e      kind;
      n = held_count;
      for (int k = 0; k < n; k++) span[k] = held[k];
      span[n] = b;
      n = n + 1;
      if (last) begin
        expected_hashes.insert(expected_hashes.size(), decode_span(span, n, running));
        restart();
        return;
      end
      if (n == 1) begin
        kind = lead_of(b);
        if (kind >= LEAD_TWO) begin
          held[0]    = b;
          held_count = 1;
          want_len   = kind;
        end else begin
          running = fold_unit16(running, (kind == LEAD_ASCII) ? {8'h00, b} : REPLACEMENT_UNIT);
        end
      end else if (n >= want_len || n >= 4) begin
        running = decode_span(span, n, running);
        restart_sequence();
      end else begin
        held[n - 1] = b;
        held_count  = n;
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_hash(logic [31:0] got);
      logic [31:0] want;
      if (expected_hashes.size() == 0) begin
        report($sformatf("hash %08h with no string waiting", got));
      end else begin
        want = expected_hashes.pop_front();
        if (got !== want) report($sformatf("hash_value %08h, expected %08h", got, want));
      end
    endtask

    task check_drained();
      while (expected_hashes.size() != 0) begin
        report($sformatf("hash %08h never delivered", expected_hashes.pop_front()));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic        in_is_last;
  logic        empty;
  logic        pop;
  logic [31:0] out_hash_value;

  utf8_to_utf16_fnv1a32_hash DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data_byte   (in_data_byte),
    .in_is_last     (in_is_last),
    .empty          (empty),
    .pop            (pop),
    .out_hash_value (out_hash_value)
  );

  utf16_hash_tracker tracker = new();

  logic [7:0] text [$];   // string being built for the next send
  int         burst_left  = 0;
  int         bytes_sent  = 0;
  int         idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitor: every edge, take what both handshakes moved. Inputs change only by
  // nonblocking updates, so the values read here are the ones the edge saw.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) tracker.take_byte(in_data_byte, in_is_last);
      if (pop && !empty) tracker.check_hash(out_hash_value);
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run when no request moves on either side for too long.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Receiver: switch among steady draining, coin-flip pops and long stalls.
  initial begin
    int mode;
    int mode_left;
    int stall;
    mode_left = 0;
    stall     = 0;
    pop <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      case (mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        default: begin
          if (stall == 0) begin
            pop   <= 1'b1;
            stall  = $urandom_range(5, 30);
          end else begin
            pop   <= 1'b0;
            stall--;
          end
        end
      endcase
    end
  end

  // Send one byte request. Bursts of random length run back to back; between
  // bursts drop push for a random gap, sometimes none at all.
  task send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(15, 40);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push         <= 1'b1;
    in_data_byte <= b;
    in_is_last   <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Push the whole text buffer as one string; mark its final byte.
  task send_text();
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
  endtask

  // Add one byte at the tail of the text buffer.
  task append_byte(input logic [7:0] b);
    text.insert(text.size(), b);
  endtask

  // Random lead byte of the given kind with random payload bits.
  function automatic logic [7:0] pick_lead(lead_e kind);
    case (kind)
      LEAD_ASCII: return 8'($urandom_range(8'h00, 8'h7F));
      LEAD_TWO:   return 8'hC0 | 8'($urandom_range(0, 31));
      LEAD_THREE: return 8'hE0 | 8'($urandom_range(0, 15));
      LEAD_FOUR:  return 8'hF0 | 8'($urandom_range(0, 7));
      default:    return $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                              : 8'($urandom_range(8'hF8, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] pick_tail();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Append one random stretch: mostly well-formed sequences, plus noise bytes,
  // sequences cut short, and leads followed by arbitrary bytes.
  task add_segment();
    int    sel;
    int    tails;
    lead_e kind;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      kind = lead_e'($urandom_range(0, 4));
      append_byte(pick_lead(kind));
      tails = (kind == LEAD_BAD) ? 0 : kind - 1;
      repeat (tails) append_byte(pick_tail());
    end else if (sel < 78) begin
      append_byte(8'($urandom_range(0, 255)));
    end else if (sel < 90) begin
      kind = lead_e'($urandom_range(LEAD_TWO, LEAD_FOUR));
      append_byte(pick_lead(kind));
      tails = $urandom_range(0, kind - 2);
      repeat (tails) append_byte(pick_tail());
    end else begin
      kind = lead_e'($urandom_range(LEAD_TWO, LEAD_FOUR));
      append_byte(pick_lead(kind));
      repeat (kind - 1) append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int segments;
    push         <= 1'b0;
    in_data_byte <= 8'h00;
    in_is_last   <= 1'b0;
    rst_n        <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings. Single NUL byte: the smallest string.
    text = '{8'h00};
    send_text();
    // ASCII, then complete two, three and four byte sequences (the last one a
    // surrogate pair), ending on the top ASCII value.
    text = '{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h7F};
    send_text();
    // Code point past the Unicode range, a stray continuation, a byte that can
    // never lead as the final byte.
    text = '{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hFF};
    send_text();
    // Four byte lead cut short by the end: its tail is read again as a pair.
    text = '{8'hF0, 8'hC3, 8'hA9};
    send_text();
    // Lone lead as the whole string.
    text = '{8'hE2};
    send_text();
    // Bad lead, a lead whose tail is not a continuation, a cut-short lead.
    text = '{8'hF8, 8'hC3, 8'h41, 8'hC2};
    send_text();

    // Random strings, kept short so that results come often.
    while (bytes_sent < RANDOM_BYTES) begin
      text.delete();
      segments = $urandom_range(1, 6);
      repeat (segments) add_segment();
      send_text();
    end
    push <= 1'b0;

    // Drain: hold until every queued hash is out, then let the block settle.
    while (tracker.expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.check_drained();

    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/u2h_pkg.sv
rtl/u2h_front.sv
rtl/u2h_fifo.sv
rtl/u2h_back.sv
rtl/utf8_to_utf16_fnv1a32_hash.sv
bench/tb_utf8_to_utf16_fnv1a32_hash.sv
